### rtl/core/ckt_pkg.sv
// Package for the C keyword token counter: scan modes, control state struct,
// character codes, the C89 keyword table and its match function.
// No dependencies.
package ckt_pkg;

    localparam int TOTAL_W   = 32;
    localparam int KW_COUNT  = 32;
    localparam int KW_MAX    = 8;

    localparam int MAX_TOKEN_CHARS_DEF = 8;
    localparam int COUNT_WIDTH_DEF     = 32;

    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;

    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_STRING,
        MODE_COMMENT,
        MODE_COMMENT_STAR
    } scan_mode_t;

    typedef struct packed {
        scan_mode_t mode;
        logic       at_line_start;
        logic       line_slash;
        logic       line_drop;
        logic       slash_pending;
        logic       tok_over;
    } ckt_ctl_t;

    localparam ckt_ctl_t CTL_RESET = '{
        mode:          MODE_NORMAL,
        at_line_start: 1'b1,
        line_slash:    1'b0,
        line_drop:     1'b0,
        slash_pending: 1'b0,
        tok_over:      1'b0
    };

    // keyword text right-justified, first character in the highest used byte
    localparam logic [8*KW_MAX-1:0] KW_TEXT [KW_COUNT] = '{
        "auto", "break", "case", "char", "const", "continue", "default", "do",
        "double", "else", "enum", "extern", "float", "for", "goto", "if",
        "int", "long", "register", "return", "short", "signed", "sizeof",
        "static", "struct", "switch", "typedef", "union", "unsigned", "void",
        "volatile", "while"
    };

    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd4, 4'd5, 4'd4, 4'd4, 4'd5, 4'd8, 4'd7, 4'd2,
        4'd6, 4'd4, 4'd4, 4'd6, 4'd5, 4'd3, 4'd4, 4'd2,
        4'd3, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd6,
        4'd6, 4'd6, 4'd6, 4'd7, 4'd5, 4'd8, 4'd4,
        4'd8, 4'd5
    };

    function automatic logic is_punct(input logic [7:0] c);
        return (c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
               (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    // text: token bytes, first character in the lowest byte
    function automatic logic keyword_match(input logic [8*KW_MAX-1:0] text,
                                           input logic [3:0] len);
        logic hit;
        logic same;
        int   j;
        hit = 1'b0;
        for (int k = 0; k < KW_COUNT; k++) begin
            same = (len == KW_LEN[k]);
            for (int i = 0; i < KW_MAX; i++) begin
                if (i < int'(KW_LEN[k])) begin
                    j = int'(KW_LEN[k]) - 1 - i;
                    same = same && (text[8*i +: 8] == KW_TEXT[k][8*j +: 8]);
                end
            end
            hit = hit | same;
        end
        return hit;
    endfunction

endpackage

### rtl/core/ckt_scan.sv
// Next-state logic for one item: line filter, string and comment scanner,
// token builder and keyword hit. Depends on ckt_pkg.
module ckt_scan #(
    parameter int MAX_TOKEN_CHARS = ckt_pkg::MAX_TOKEN_CHARS_DEF
) (
    input  ckt_pkg::ckt_ctl_t                          ctl,
    input  logic [$clog2(MAX_TOKEN_CHARS+1)-1:0]       tok_len,
    input  logic [MAX_TOKEN_CHARS-1:0][7:0]            tok_chars,
    input  logic [7:0]                                 text_byte,
    input  logic                                       end_of_text,
    output ckt_pkg::ckt_ctl_t                          ctl_next,
    output logic [$clog2(MAX_TOKEN_CHARS+1)-1:0]       tok_len_next,
    output logic [MAX_TOKEN_CHARS-1:0][7:0]            tok_chars_next,
    output logic                                       kw_hit
);
    import ckt_pkg::*;

    localparam int LEN_W = $clog2(MAX_TOKEN_CHARS + 1);
    localparam int IDX_W = $clog2(MAX_TOKEN_CHARS);

    typedef struct packed {
        ckt_ctl_t                        ctl;
        logic [LEN_W-1:0]                len;
        logic [MAX_TOKEN_CHARS-1:0][7:0] chars;
        logic                            closed;
        logic [LEN_W-1:0]                cl_len;
        logic [MAX_TOKEN_CHARS-1:0][7:0] cl_chars;
    } work_t;

    // closed marks a non-empty token closed; at most one per item, kept in cl_*
    function automatic work_t close_tok(input work_t w);
        work_t r;
        r = w;
        if (!w.ctl.tok_over && w.len != '0) begin
            r.closed   = 1'b1;
            r.cl_len   = w.len;
            r.cl_chars = w.chars;
        end
        r.len = '0;
        r.ctl.tok_over = 1'b0;
        return r;
    endfunction

    function automatic work_t normal_byte(input work_t w, input logic [7:0] c);
        work_t r;
        r = w;
        if (c == CH_QUOTE) begin
            r.ctl.mode = MODE_STRING;
        end else if (c == CH_SLASH) begin
            r = close_tok(w);
            r.ctl.slash_pending = 1'b1;
        end else if (is_punct(c) || is_space(c)) begin
            r = close_tok(w);
        end else if (w.len < LEN_W'(MAX_TOKEN_CHARS)) begin
            r.chars[w.len[IDX_W-1:0]] = c;
            r.len = w.len + LEN_W'(1);
        end else begin
            r.ctl.tok_over = 1'b1;
        end
        return r;
    endfunction

    function automatic work_t scan_byte(input work_t w, input logic [7:0] c);
        work_t r;
        r = w;
        case (w.ctl.mode)
            MODE_STRING:
            begin
                if (c == CH_QUOTE)
                    r.ctl.mode = MODE_NORMAL;
            end
            MODE_COMMENT, MODE_COMMENT_STAR:
            begin
                if (w.ctl.mode == MODE_COMMENT_STAR && c == CH_SLASH) begin
                    r.ctl.mode = MODE_NORMAL;
                    r = normal_byte(r, c);
                end else begin
                    r.ctl.mode = (c == CH_STAR) ? MODE_COMMENT_STAR : MODE_COMMENT;
                end
            end
            default:
            begin
                r.ctl.mode = MODE_NORMAL;
                if (w.ctl.slash_pending && c == CH_STAR) begin
                    r.ctl.slash_pending = 1'b0;
                    r.ctl.mode = MODE_COMMENT_STAR;
                end else begin
                    r.ctl.slash_pending = 1'b0;
                    r = normal_byte(r, c);
                end
            end
        endcase
        return r;
    endfunction

    function automatic work_t body_byte(input work_t w, input logic [7:0] c);
        work_t r;
        if (c == CH_LF) begin
            r = scan_byte(w, CH_SPACE);
            r.ctl.at_line_start = 1'b1;
        end else begin
            r = scan_byte(w, c);
        end
        return r;
    endfunction

    function automatic work_t line_byte(input work_t w, input logic [7:0] c);
        work_t r;
        r = w;
        if (w.ctl.line_drop) begin
            if (c == CH_LF) begin
                r.ctl.line_drop = 1'b0;
                r.ctl.at_line_start = 1'b1;
            end
        end else if (w.ctl.line_slash) begin
            r.ctl.line_slash = 1'b0;
            if (c == CH_SLASH) begin
                r.ctl.line_drop = 1'b1;
            end else begin
                r = scan_byte(r, CH_SLASH);
                r = body_byte(r, c);
            end
        end else if (w.ctl.at_line_start && c == CH_SPACE) begin
            r = scan_byte(w, c);
        end else if (w.ctl.at_line_start && c == CH_SLASH) begin
            r.ctl.at_line_start = 1'b0;
            r.ctl.line_slash = 1'b1;
        end else begin
            r.ctl.at_line_start = 1'b0;
            r = body_byte(r, c);
        end
        return r;
    endfunction

    work_t w_in;
    work_t w_line;
    work_t w_out;
    logic  start_match;

    always_comb
    begin
        w_in.ctl      = ctl;
        w_in.len      = tok_len;
        w_in.chars    = tok_chars;
        w_in.closed   = 1'b0;
        w_in.cl_len   = '0;
        w_in.cl_chars = '0;
        w_line = line_byte(w_in, text_byte);
        w_out  = w_line;
        if (end_of_text) begin
            if (w_line.ctl.line_slash) begin
                w_out.ctl.line_slash = 1'b0;
                w_out = scan_byte(w_out, CH_SLASH);
            end
            w_out = close_tok(w_out);
        end
    end

    assign start_match = (w_out.cl_len <= LEN_W'(KW_MAX)) &&
                         keyword_match(w_out.cl_chars[KW_MAX-1:0], w_out.cl_len[3:0]);

    assign ctl_next       = w_out.ctl;
    assign tok_len_next   = w_out.len;
    assign tok_chars_next = w_out.chars;
    assign kw_hit         = w_out.closed && start_match;

endmodule

### rtl/core/c_keyword_token_counter.sv
// C keyword token counter, top level: state registers, saturating count,
// output register and handshake. Depends on ckt_pkg and ckt_scan.
//
// Usage:
//   Slave stream (s_*) carries the source text, one byte per item; s_tlast
//   marks the final byte of a text. Master stream (m_*) carries one item per
//   text: the number of C89 keyword tokens found, saturating at 0xFFFFFFFF.
//   Throughput is one byte per cycle while s_tready is high; the whole scan
//   for a byte is done in the cycle it is accepted, against the registered
//   scanner state. The total is registered when the last byte is accepted,
//   shows on m_tdata in the next cycle and stays there until taken.
//   While a total waits with m_tready low, s_tready is low; a taken total
//   frees the input in the same cycle.
//   After the last byte the scanner state and count return to their reset
//   values, so the next text may follow at once.
//   Reset clears the scanner state, the count and the output valid; the
//   token character buffer is not cleared.
module c_keyword_token_counter #(
    parameter int MAX_TOKEN_CHARS = ckt_pkg::MAX_TOKEN_CHARS_DEF,
    parameter int COUNT_WIDTH     = ckt_pkg::COUNT_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] text_byte
    input  logic                        s_tlast,   // end_of_text
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [ckt_pkg::TOTAL_W-1:0] m_tdata    // [31:0] keyword_total
);
    import ckt_pkg::*;

    localparam int LEN_W = $clog2(MAX_TOKEN_CHARS + 1);

    ckt_ctl_t                        ctl_reg;
    ckt_ctl_t                        ctl_next;
    logic [LEN_W-1:0]                tok_len_reg;
    logic [LEN_W-1:0]                tok_len_next;
    logic [MAX_TOKEN_CHARS-1:0][7:0] tok_chars_reg;
    logic [MAX_TOKEN_CHARS-1:0][7:0] tok_chars_next;
    logic [COUNT_WIDTH-1:0]          count_reg;
    logic [COUNT_WIDTH-1:0]          count_next;
    logic                            out_valid_reg;
    logic [TOTAL_W-1:0]              out_data_reg;
    logic [TOTAL_W-1:0]              total;
    logic                            kw_hit;
    logic                            accept;

    ckt_scan #(
        .MAX_TOKEN_CHARS(MAX_TOKEN_CHARS)
    ) u_scan (
        .ctl            (ctl_reg),
        .tok_len        (tok_len_reg),
        .tok_chars      (tok_chars_reg),
        .text_byte      (s_tdata),
        .end_of_text    (s_tlast),
        .ctl_next       (ctl_next),
        .tok_len_next   (tok_len_next),
        .tok_chars_next (tok_chars_next),
        .kw_hit         (kw_hit)
    );

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign count_next = (kw_hit && count_reg != '1) ? count_reg + COUNT_WIDTH'(1)
                                                    : count_reg;

    generate
        if (COUNT_WIDTH > TOTAL_W) begin : g_sat
            assign total = (count_next > COUNT_WIDTH'({TOTAL_W{1'b1}}))
                           ? {TOTAL_W{1'b1}} : count_next[TOTAL_W-1:0];
        end else begin : g_ext
            assign total = TOTAL_W'(count_next);
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ctl_reg       <= CTL_RESET;
            tok_len_reg   <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (m_tready)
                out_valid_reg <= 1'b0;
            if (accept) begin
                if (s_tlast) begin
                    ctl_reg       <= CTL_RESET;
                    tok_len_reg   <= '0;
                    count_reg     <= '0;
                    out_valid_reg <= 1'b1;
                end else begin
                    ctl_reg     <= ctl_next;
                    tok_len_reg <= tok_len_next;
                    count_reg   <= count_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            tok_chars_reg <= tok_chars_next;
            if (s_tlast)
                out_data_reg <= total;
        end
    end

    a_out_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast))
        else $error("total shown without a last item");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tlast) |=> (count_reg == '0 && tok_len_reg == '0))
        else $error("state not cleared after last item");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tok_len_reg <= LEN_W'(MAX_TOKEN_CHARS))
        else $error("token length beyond buffer");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while total stalled");

endmodule
